// ===== hw/rtl/json_string_unescape_utf8_check_macros.svh =====
// Assertion macros for the port-level checker.
`ifndef JSON_STRING_UNESCAPE_UTF8_CHECK_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_CHECK_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define JSU_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define JSU_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants for the JSON string decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package jsu_pkg;
  typedef enum logic [3:0] {
    PH_WAIT = 4'd0,
    PH_BODY = 4'd1,
    PH_ESC  = 4'd2,
    PH_HEX  = 4'd3,
    PH_PAIR = 4'd4,
    PH_UTF8 = 4'd5,
    PH_DROP = 4'd6
  } phase_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_JSON  = 3'd1;
  localparam logic [2:0] ST_UTF8  = 3'd2;
  localparam logic [2:0] ST_LIMIT = 3'd3;
  localparam logic [2:0] ST_QUOTE = 3'd4;

  localparam int MaxRes = 5;
  localparam int ResCntW = 3;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [19:0] offset;
    logic [20:0] count;
  } res_t;

  // group of results caused by one input item
  typedef struct packed {
    logic [ResCntW-1:0] n;
    res_t [MaxRes-1:0]  r;
  } res_grp_t;

  function automatic logic [4:0] hexval(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b0, b[3:0]};
    if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
      return 5'(b[3:0] + 4'd9);
    return 5'h10;
  endfunction

  function automatic logic [1:0] cont_count(input logic [7:0] lead);
    if (lead >= 8'hc2 && lead <= 8'hdf) return 2'd1;
    if (lead >= 8'he0 && lead <= 8'hef) return 2'd2;
    if (lead >= 8'hf0 && lead <= 8'hf4) return 2'd3;
    return 2'd0;
  endfunction
endpackage

// ===== hw/rtl/json_string_unescape_utf8_check.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_check
// Streaming JSON string literal decoder with UTF-8 checking.
//
//  channel   dir  fields
//  s_axis    in   tdata: in_byte; tlast: in_last
//  m_axis    out  tdata: out_byte, status, err_offset, err_count; tuser: out_kind
//  cfg       in   byte_limit (write only)
//
//  One byte per cycle; each byte is decoded in the cycle it is accepted and
//  its 0..5 results enter an 8-entry queue drained one per cycle while m_axis_tready is high.
//  Input stalls only when the queue lacks room for five results.
//  Synchronous reset clears state and the queue; limit resets to 4096.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module json_string_unescape_utf8_check import jsu_pkg::*; #(
  parameter int OFFSET_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_byte, status, err_offset, err_count
  output logic        m_axis_tuser,   // out_kind
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata
);
  logic [19:0] byte_limit;
  logic        step, room;
  res_grp_t    grp;
  res_t        head;

  always_ff @(posedge clk) begin
    if (rst) byte_limit <= 20'd4096;
    else if (cfg_we) byte_limit <= cfg_wdata;
  end

  assign s_axis_tready = room;
  assign step = s_axis_tvalid && room;

  jsu_core #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_core (
    .clk, .rst, .step,
    .in_byte(s_axis_tdata), .in_last(s_axis_tlast),
    .max_bytes(byte_limit), .grp
  );

  jsu_outq u_outq (
    .clk, .rst, .push(step), .grp, .room,
    .valid(m_axis_tvalid), .pop(m_axis_tready), .head
  );

  assign m_axis_tdata = {4'd0, head.count, head.offset, head.status, head.data};
  assign m_axis_tuser = head.kind;
endmodule

// ===== hw/rtl/jsu_core.sv =====
// ----------------------------------------------------------------------------
// jsu_core
// Per-byte decode: state registers and the combinational step that yields
// the group of results for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jsu_core import jsu_pkg::*; #(
  parameter int OFFSET_WIDTH = 20
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  logic [19:0]    max_bytes,
  output res_grp_t       grp
);
  localparam logic [OFFSET_WIDTH-1:0] OffMax = '1;

  phase_t                  phase, phase_next;
  logic [OFFSET_WIDTH-1:0] byte_offset, byte_offset_next;
  logic [20:0]             decoded_count, decoded_count_next;
  logic [15:0]             hex_accum, hex_accum_next;
  logic [2:0]              hex_digits_seen, hex_digits_seen_next;
  logic [OFFSET_WIDTH-1:0] bad_digit_offset, bad_digit_offset_next;
  logic                    bad_digit_rec, bad_digit_rec_next;
  logic [9:0]              high_surrogate, high_surrogate_next;
  logic [7:0]              held [4];
  logic [7:0]              held_next [4];
  logic [1:0]              seq_remaining, seq_remaining_next;
  logic [20:0]             seq_codepoint, seq_codepoint_next;
  logic [OFFSET_WIDTH-1:0] seq_bad_offset, seq_bad_offset_next;
  logic                    seq_bad_rec, seq_bad_rec_next;
  logic [OFFSET_WIDTH-1:0] seq_start_offset, seq_start_offset_next;

  function automatic logic [OFFSET_WIDTH-1:0] inc_sat(input logic [OFFSET_WIDTH-1:0] x);
    return (x == OffMax) ? x : x + 1'b1;
  endfunction

  function automatic logic [19:0] clamp20(input logic [OFFSET_WIDTH-1:0] x);
    logic [OFFSET_WIDTH+19:0] w;
    w = {20'd0, x};
    return (w > (OFFSET_WIDTH+20)'(20'hfffff)) ? 20'hfffff : w[19:0];
  endfunction

  always_comb begin
    logic [OFFSET_WIDTH-1:0] cur, cur1;
    logic [4:0]  d;
    logic [1:0]  n;
    logic [15:0] acc;
    logic [2:0]  k;
    logic [20:0] cp, total, cnt;
    logic [1:0]  ncp;
    logic        do_app, fin;
    logic [2:0]  fst;
    logic [19:0] foff;
    logic [20:0] fcnt;
    logic [7:0]  ub [4];
    logic [2:0]  un;
    logic [7:0]  b;
    res_t        z;
    cur = byte_offset;
    cur1 = inc_sat(cur);
    b = in_byte;
    d = hexval(b);
    n = 2'd0; acc = '0; k = '0; cp = '0; total = '0; cnt = '0; ncp = '0;
    do_app = 1'b0; fin = 1'b0; fst = ST_OK; foff = '0; fcnt = '0;
    un = '0;
    for (int i = 0; i < 4; i++) ub[i] = '0;
    z = '0;
    phase_next = phase;
    byte_offset_next = cur1;
    decoded_count_next = decoded_count;
    hex_accum_next = hex_accum;
    hex_digits_seen_next = hex_digits_seen;
    bad_digit_offset_next = bad_digit_offset;
    bad_digit_rec_next = bad_digit_rec;
    high_surrogate_next = high_surrogate;
    for (int i = 0; i < 4; i++) held_next[i] = held[i];
    seq_remaining_next = seq_remaining;
    seq_codepoint_next = seq_codepoint;
    seq_bad_offset_next = seq_bad_offset;
    seq_bad_rec_next = seq_bad_rec;
    seq_start_offset_next = seq_start_offset;

    unique case (phase)
      PH_WAIT: begin
        if (b != 8'h22) begin
          fin = 1'b1; fst = ST_QUOTE;
        end else begin
          cur = '0;
          byte_offset_next = OFFSET_WIDTH'(1);
          decoded_count_next = '0;
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        n = cont_count(b);
        if (b == 8'h22) begin
          fin = 1'b1; fst = ST_OK;
        end else if (b < 8'h20) begin
          fin = 1'b1; fst = ST_JSON; foff = clamp20(cur);
        end else if (b == 8'h5c) begin
          phase_next = PH_ESC;
        end else if (b < 8'h80) begin
          do_app = 1'b1; cp = {13'd0, b};
        end else if (n == 2'd0) begin
          fin = 1'b1; fst = ST_UTF8; foff = clamp20(cur);
        end else begin
          held_next[0] = b;
          seq_remaining_next = n;
          seq_codepoint_next = {16'd0, b[4:0] & ((n == 2'd1) ? 5'h1f :
                                (n == 2'd2) ? 5'h0f : 5'h07)};
          seq_bad_rec_next = 1'b0;
          seq_bad_offset_next = '0;
          seq_start_offset_next = cur;
          phase_next = PH_UTF8;
        end
      end
      PH_ESC: begin
        phase_next = PH_BODY;
        do_app = 1'b1;
        unique case (b)
          8'h75: begin
            do_app = 1'b0;
            hex_accum_next = '0;
            hex_digits_seen_next = '0;
            bad_digit_rec_next = 1'b0;
            bad_digit_offset_next = '0;
            seq_start_offset_next = cur1;
            phase_next = PH_HEX;
          end
          8'h22, 8'h5c, 8'h2f: cp = {13'd0, b};
          8'h62: cp = 21'h08;
          8'h66: cp = 21'h0c;
          8'h6e: cp = 21'h0a;
          8'h72: cp = 21'h0d;
          8'h74: cp = 21'h09;
          default: begin
            do_app = 1'b0; phase_next = phase;
            fin = 1'b1; fst = ST_JSON; foff = clamp20(cur);
          end
        endcase
      end
      PH_HEX: begin
        if (d[4] && !bad_digit_rec) begin
          bad_digit_rec_next = 1'b1;
          bad_digit_offset_next = cur;
        end
        acc = {hex_accum[11:0], d[3:0]};
        hex_accum_next = acc;
        hex_digits_seen_next = hex_digits_seen + 3'd1;
        if (hex_digits_seen == 3'd3) begin
          if (bad_digit_rec_next) begin
            fin = 1'b1; fst = ST_JSON; foff = clamp20(bad_digit_offset_next);
          end else if (acc >= 16'hd800 && acc <= 16'hdbff) begin
            high_surrogate_next = acc[9:0];
            hex_accum_next = '0;
            hex_digits_seen_next = '0;
            bad_digit_rec_next = 1'b0;
            seq_bad_rec_next = 1'b0;
            seq_start_offset_next = cur1;
            phase_next = PH_PAIR;
          end else if (acc >= 16'hdc00 && acc <= 16'hdfff) begin
            fin = 1'b1; fst = ST_UTF8; foff = clamp20(cur1);
          end else begin
            phase_next = PH_BODY;
            do_app = 1'b1; cp = {5'd0, acc};
          end
        end
      end
      PH_PAIR: begin
        k = hex_digits_seen;
        acc = hex_accum;
        if (k == 3'd0) begin
          if (b != 8'h5c) seq_bad_rec_next = 1'b1;
        end else if (k == 3'd1) begin
          if (b != 8'h75) seq_bad_rec_next = 1'b1;
        end else begin
          if (d[4] && !bad_digit_rec) begin
            bad_digit_rec_next = 1'b1;
            bad_digit_offset_next = cur;
          end
          acc = {hex_accum[11:0], d[3:0]};
          hex_accum_next = acc;
        end
        hex_digits_seen_next = k + 3'd1;
        if (k == 3'd5) begin
          if (seq_bad_rec_next) begin
            fin = 1'b1; fst = ST_UTF8; foff = clamp20(seq_start_offset);
          end else if (bad_digit_rec_next) begin
            fin = 1'b1; fst = ST_UTF8; foff = clamp20(inc_sat(bad_digit_offset_next));
          end else if (acc < 16'hdc00 || acc > 16'hdfff) begin
            fin = 1'b1; fst = ST_UTF8; foff = clamp20(cur1);
          end else begin
            phase_next = PH_BODY;
            do_app = 1'b1;
            cp = 21'h10000 + {1'b0, high_surrogate, acc[9:0]};
          end
        end
      end
      PH_UTF8: begin
        n = cont_count(held[0]);
        held_next[2'(n - seq_remaining + 2'd1)] = b;
        if (b[7:6] != 2'b10 && !seq_bad_rec) begin
          seq_bad_rec_next = 1'b1;
          seq_bad_offset_next = cur;
        end
        cp = {seq_codepoint[14:0], b[5:0]};
        seq_codepoint_next = cp;
        seq_remaining_next = seq_remaining - 2'd1;
        if (seq_remaining == 2'd1) begin
          total = decoded_count + 21'(n) + 21'd1;
          if (total > {1'b0, max_bytes}) begin
            fin = 1'b1; fst = ST_LIMIT; fcnt = total;
          end else if (seq_bad_rec_next) begin
            fin = 1'b1; fst = ST_UTF8; foff = clamp20(seq_bad_offset_next);
          end else if ((n == 2'd2 && cp < 21'h800) || (n == 2'd3 && cp < 21'h10000) ||
                       (cp >= 21'hd800 && cp <= 21'hdfff) || cp > 21'h10ffff) begin
            fin = 1'b1; fst = ST_UTF8; foff = clamp20(cur1);
          end else begin
            decoded_count_next = total;
            un = 3'(n) + 3'd1;
            for (int i = 0; i < 4; i++) ub[i] = held_next[i];
            phase_next = PH_BODY;
          end
        end
        cp = '0;
      end
      default: ;
    endcase

    if (do_app) begin
      ncp = (cp <= 21'h7f) ? 2'd0 : (cp <= 21'h7ff) ? 2'd1 :
            (cp <= 21'hffff) ? 2'd2 : 2'd3;
      cnt = decoded_count + 21'(ncp) + 21'd1;
      decoded_count_next = cnt;
      if (cnt > {1'b0, max_bytes}) begin
        fin = 1'b1; fst = ST_LIMIT; fcnt = cnt;
        phase_next = phase;
      end else begin
        un = 3'(ncp) + 3'd1;
        unique case (ncp)
          2'd0: ub[0] = cp[7:0];
          2'd1: begin
            ub[0] = {3'b110, cp[10:6]}; ub[1] = {2'b10, cp[5:0]};
          end
          2'd2: begin
            ub[0] = {4'b1110, cp[15:12]}; ub[1] = {2'b10, cp[11:6]};
            ub[2] = {2'b10, cp[5:0]};
          end
          default: begin
            ub[0] = {5'b11110, cp[20:18]}; ub[1] = {2'b10, cp[17:12]};
            ub[2] = {2'b10, cp[11:6]}; ub[3] = {2'b10, cp[5:0]};
          end
        endcase
      end
    end
    if (fin) phase_next = PH_DROP;

    if (in_last) begin
      if (!fin) begin
        priority case (phase_next)
          PH_BODY, PH_ESC: begin fin = 1'b1; fst = ST_JSON; foff = clamp20(cur1); end
          PH_HEX:  begin fin = 1'b1; fst = ST_JSON; foff = clamp20(seq_start_offset_next); end
          PH_PAIR: begin fin = 1'b1; fst = ST_UTF8; foff = clamp20(seq_start_offset_next); end
          PH_UTF8: begin
            fin = 1'b1; fst = ST_UTF8; foff = clamp20(inc_sat(seq_start_offset_next));
          end
          default: ;
        endcase
      end
      phase_next = PH_WAIT;
      byte_offset_next = '0;
    end else if (phase_next == PH_DROP) begin
      byte_offset_next = '0;
    end

    grp = '0;
    for (int i = 0; i < 4; i++) begin
      grp.r[i] = z;
      grp.r[i].data = ub[i];
    end
    grp.n = un;
    if (fin) begin
      grp.r[un].kind = 1'b1;
      grp.r[un].data = '0;
      grp.r[un].status = fst;
      grp.r[un].offset = (fst == ST_JSON || fst == ST_UTF8) ? foff : 20'd0;
      grp.r[un].count = fcnt;
      grp.n = un + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      byte_offset <= '0;
      decoded_count <= '0;
      hex_accum <= '0;
      hex_digits_seen <= '0;
      bad_digit_offset <= '0;
      bad_digit_rec <= 1'b0;
      high_surrogate <= '0;
      seq_remaining <= '0;
      seq_codepoint <= '0;
      seq_bad_offset <= '0;
      seq_bad_rec <= 1'b0;
      seq_start_offset <= '0;
    end else if (step) begin
      phase <= phase_next;
      byte_offset <= byte_offset_next;
      decoded_count <= decoded_count_next;
      hex_accum <= hex_accum_next;
      hex_digits_seen <= hex_digits_seen_next;
      bad_digit_offset <= bad_digit_offset_next;
      bad_digit_rec <= bad_digit_rec_next;
      high_surrogate <= high_surrogate_next;
      seq_remaining <= seq_remaining_next;
      seq_codepoint <= seq_codepoint_next;
      seq_bad_offset <= seq_bad_offset_next;
      seq_bad_rec <= seq_bad_rec_next;
      seq_start_offset <= seq_start_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 4; i++) held[i] <= held_next[i];
    end
  end
endmodule

// ===== hw/rtl/jsu_outq.sv =====
// ----------------------------------------------------------------------------
// jsu_outq
// Result queue: takes a group of up to five results per cycle and sends one
// per cycle on pop. Takes a new group while earlier results drain, given room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module jsu_outq import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  res_grp_t grp,
  output logic     room,
  output logic     valid,
  input  logic     pop,
  output res_t     head
);
  localparam int Depth = 8;
  localparam int PtrW = 3;

  res_t            q [Depth];
  logic [PtrW-1:0] rd, wr;
  logic [PtrW:0]   used, used_next;

  assign valid = used != '0;
  assign head  = q[rd];
  assign room  = (used - {3'd0, pop && valid}) <= (PtrW+1)'(Depth - MaxRes);

  always_comb begin
    used_next = used - {3'd0, pop && valid};
    if (push) used_next = used_next + {1'b0, grp.n};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0;
      wr <= '0;
      used <= '0;
    end else begin
      if (pop && valid) rd <= rd + 1'b1;
      if (push) wr <= wr + grp.n;
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < MaxRes; i++) begin
        if (3'(i) < grp.n) q[PtrW'(wr + PtrW'(i))] <= grp.r[i];
      end
    end
  end
endmodule

// ===== hw/rtl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks for the JSON string decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_string_unescape_utf8_check_macros.svh"
module jsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  `JSU_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
  `JSU_ASSERT_IMP(a_data_clean, clk, rst, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[55:8] == 48'd0, "data item carries status")
  `JSU_ASSERT_IMP(a_status_range, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[10:8] <= 3'd4 && m_axis_tdata[7:0] == 8'd0, "bad status item")
  `JSU_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_axis_tvalid, "output valid after reset")
  `JSU_ASSERT_IMP(a_stall_busy, clk, rst, s_axis_tvalid && !s_axis_tready, m_axis_tvalid, "input stalled with empty queue")
endmodule

bind json_string_unescape_utf8_check jsu_checker u_jsu_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tuser
);
